// File: hw/rtl/pvdea_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvdea_pkg
// Types, widths and constants shared by the PV daily energy accumulator.
// ----------------------------------------------------------------------------
package pvdea_pkg;

    localparam int TIME_W   = 32;
    localparam int VOLT_W   = 14;
    localparam int CURR_W   = 14;
    localparam int PWR_W    = 27;
    localparam int ENERGY_W = 63;

    // serial multiplier: a power (up to 28 bits) times a time span, or voltage times current
    localparam int MUL_A_W   = 28;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam int ACC_CNT_W = $clog2(ENERGY_W);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic REG_DARK_THR = 1'b0;
    localparam logic REG_DARK_MS  = 1'b1;

    localparam logic [VOLT_W-1:0] DARK_THR_RST = VOLT_W'(300);
    localparam logic [TIME_W-1:0] DARK_MS_RST  = TIME_W'(6 * 3600000);

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [VOLT_W-1:0] pv_voltage;
        logic [CURR_W-1:0] pv_current;
        logic [PWR_W-1:0]  pv_power;
    } t_pvdea_in;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy_total;
        logic                night_now;
        logic                reset_armed;
        logic                sunrise_seen;
        logic                energy_cleared;
    } t_pvdea_out;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                clear;
        logic                start;
        logic [ENERGY_W-1:0] addend;
    } t_acc_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage
`default_nettype wire

// File: hw/rtl/pv_daily_energy_accumulator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pv_daily_energy_accumulator_unit
// Night/day tracking of PV samples and saturating energy total in mW*ms.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_pvdea_in)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_pvdea_out)
//  cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One item at a time. Night sample or first day sample: accept, evaluate,
// result. Other day samples also pass through the serial multiplier and the
// bit-serial adder; zero reported power adds a second multiplier pass.
// Synchronous reset; no clearing pass. A stalled result holds in the output
// register while the next item is accepted and worked on.
// ----------------------------------------------------------------------------
module pv_daily_energy_accumulator_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire pvdea_pkg::t_pvdea_in            i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output pvdea_pkg::t_pvdea_out                o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pvdea_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [pvdea_pkg::PDATA_W-1:0]   pwdata,
    output logic [pvdea_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready
);
    import pvdea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PMUL,
        S_EMUL,
        S_ADD,
        S_DONE
    } t_state;

    t_state             r_state;
    t_pvdea_in          r_item;
    t_pvdea_out         r_out;
    logic               r_out_valid;
    logic [VOLT_W-1:0]  r_dark_thr;
    logic [TIME_W-1:0]  r_dark_ms;
    logic               r_night;
    logic [TIME_W-1:0]  r_night_start;
    logic               r_long_dark;
    logic [TIME_W-1:0]  r_last_time;
    logic               r_await;
    logic [TIME_W-1:0]  r_delta;
    logic               r_sunrise;
    logic               r_cleared;

    logic               w_is_dark;
    logic [TIME_W-1:0]  w_dur;
    logic [TIME_W-1:0]  w_delta;
    logic               w_pwr_zero;
    logic               w_out_free;
    logic               w_cfg_wr;

    t_mul_req           w_mul_req;
    t_unit_sts          w_mul_sts;
    logic [MUL_P_W-1:0] w_product;
    t_acc_req           w_acc_req;
    t_unit_sts          w_acc_sts;
    logic [ENERGY_W-1:0] w_total;

    assign w_is_dark  = r_item.pv_voltage <= r_dark_thr;
    assign w_dur      = r_item.time_ms - r_night_start;
    assign w_delta    = r_item.time_ms - r_last_time;
    assign w_pwr_zero = r_item.pv_power == '0;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // ---- configuration --------------------------------------------------
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_DARK_THR: prdata = {{(PDATA_W-VOLT_W){1'b0}}, r_dark_thr};
            REG_DARK_MS:  prdata = r_dark_ms;
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_thr <= DARK_THR_RST;
            r_dark_ms  <= DARK_MS_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_DARK_THR: r_dark_thr <= pwdata[VOLT_W-1:0];
                REG_DARK_MS:  r_dark_ms  <= pwdata[TIME_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---- requests to the serial units -----------------------------------
    always_comb begin
        w_mul_req = '{start: 1'b0, a: '0, b: '0};
        if (r_state == S_EVAL && !w_is_dark && !r_await) begin
            w_mul_req.start = 1'b1;
            if (w_pwr_zero) begin
                w_mul_req.a = MUL_A_W'(r_item.pv_voltage);
                w_mul_req.b = MUL_B_W'(r_item.pv_current);
            end else begin
                w_mul_req.a = MUL_A_W'(r_item.pv_power);
                w_mul_req.b = w_delta;
            end
        end else if (r_state == S_PMUL && w_mul_sts.done) begin
            // volt*curr fits the multiplicand width; now scale by the interval
            w_mul_req.start = 1'b1;
            w_mul_req.a     = w_product[MUL_A_W-1:0];
            w_mul_req.b     = r_delta;
        end
    end

    always_comb begin
        w_acc_req.clear  = r_state == S_EVAL && !w_is_dark && r_night && r_long_dark;
        w_acc_req.start  = r_state == S_EMUL && w_mul_sts.done;
        w_acc_req.addend = ENERGY_W'(w_product);
    end

    pvdea_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mul_req),
        .o_sts     (w_mul_sts),
        .o_product (w_product)
    );

    pvdea_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_acc_req),
        .o_sts   (w_acc_sts),
        .o_total (w_total)
    );

    // ---- sequencer --------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_night       <= 1'b0;
            r_night_start <= '0;
            r_long_dark   <= 1'b0;
            r_last_time   <= '0;
            r_await       <= 1'b1;
            r_sunrise     <= 1'b0;
            r_cleared     <= 1'b0;
        end else begin
            // the result stage reloads the register itself when it is free
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_last_time <= r_item.time_ms;
                    r_delta     <= w_delta;
                    if (w_is_dark) begin
                        r_sunrise <= 1'b0;
                        r_cleared <= 1'b0;
                        if (!r_night) begin
                            r_night       <= 1'b1;
                            r_night_start <= r_item.time_ms;
                            r_long_dark   <= 1'b0;
                        end else if (w_dur >= r_dark_ms) begin
                            r_long_dark <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_sunrise <= r_night;
                        r_cleared <= r_night && r_long_dark;
                        r_night   <= 1'b0;
                        if (r_night && r_long_dark) begin
                            r_long_dark <= 1'b0;
                        end
                        if (r_await) begin
                            r_await <= 1'b0;
                            r_state <= S_DONE;
                        end else if (w_pwr_zero) begin
                            r_state <= S_PMUL;
                        end else begin
                            r_state <= S_EMUL;
                        end
                    end
                end
                S_PMUL: begin
                    if (w_mul_sts.done) begin
                        r_state <= S_EMUL;
                    end
                end
                S_EMUL: begin
                    if (w_mul_sts.done) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (w_acc_sts.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.energy_total   <= w_total;
                        r_out.night_now      <= r_night;
                        r_out.reset_armed    <= r_long_dark;
                        r_out.sunrise_seen   <= r_sunrise;
                        r_out.energy_cleared <= r_cleared;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- assertions -------------------------------------------------------
    a_units_idle_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!w_mul_sts.busy && !w_acc_sts.busy))
        else $error("result stage reached with a serial unit still running");

    a_night_vs_sunrise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.night_now && o_out_data.sunrise_seen))
        else $error("item reports night and sunrise together");

    a_clear_at_sunrise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.energy_cleared)
            |-> (o_out_data.sunrise_seen && !o_out_data.reset_armed))
        else $error("total cleared outside a sunrise");

    a_first_ref_on_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_await) |-> ($past(r_state) == S_EVAL))
        else $error("time reference taken outside evaluation");

endmodule
`default_nettype wire

// File: hw/rtl/pvdea_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvdea_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pvdea_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pvdea_pkg::t_mul_req           i_req,
    output pvdea_pkg::t_unit_sts               o_sts,
    output logic [pvdea_pkg::MUL_P_W-1:0]      o_product
);
    import pvdea_pkg::*;

    localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_B_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_A_W-1:0]   r_hi;
    logic [MUL_B_W-1:0]   r_lo;
    logic [MUL_A_W:0]     n_sum;

    // partial product add on the upper half, then the pair shifts right
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(MUL_A_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_hi <= '0;
            r_lo <= i_req.b;
        end else if (r_busy) begin
            r_hi <= n_sum[MUL_A_W:1];
            r_lo <= {n_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_sts     = '{busy: r_busy, done: r_done};
    assign o_product = {r_hi, r_lo};

endmodule
`default_nettype wire

// File: hw/rtl/pvdea_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvdea_acc
// Energy total with a bit-serial saturating adder, one bit per cycle.
// ----------------------------------------------------------------------------
module pvdea_acc (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pvdea_pkg::t_acc_req           i_req,
    output pvdea_pkg::t_unit_sts               o_sts,
    output logic [pvdea_pkg::ENERGY_W-1:0]     o_total
);
    import pvdea_pkg::*;

    localparam logic [ACC_CNT_W-1:0] LAST = ACC_CNT_W'(ENERGY_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [ACC_CNT_W-1:0] r_cnt;
    logic [ENERGY_W-1:0]  r_acc;
    logic [ENERGY_W-1:0]  r_add;
    logic                 r_carry;
    logic                 n_sum;
    logic                 n_carry;

    assign n_sum   = r_acc[0] ^ r_add[0] ^ r_carry;
    assign n_carry = (r_acc[0] & r_add[0]) | (r_carry & (r_acc[0] ^ r_add[0]));

    // total rotates through the adder; a carry out of the top bit saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_carry <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.clear) begin
                r_acc <= '0;
            end else if (i_req.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_carry <= 1'b0;
            end else if (r_busy) begin
                r_cnt   <= r_cnt + 1'b1;
                r_carry <= n_carry;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_acc  <= n_carry ? {ENERGY_W{1'b1}} : {n_sum, r_acc[ENERGY_W-1:1]};
                end else begin
                    r_acc <= {n_sum, r_acc[ENERGY_W-1:1]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_add <= i_req.addend;
        end else if (r_busy) begin
            r_add <= {1'b0, r_add[ENERGY_W-1:1]};
        end
    end

    assign o_sts   = '{busy: r_busy, done: r_done};
    assign o_total = r_acc;

endmodule
`default_nettype wire

// File: tb/pv_daily_energy_accumulator_unit_test.sv
// ----------------------------------------------------------------------------
// pv_daily_energy_accumulator_unit_test
// Drives PV samples through the accumulator and predicts every result from an
// in-bench model of the night/day tracking and saturating energy total.
// Covers directed corner items, saturation, back-pressure and random
// traffic under several threshold settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module pv_daily_energy_accumulator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pvdea_pkg::*;

    localparam int          QUIET_LIMIT = 5000;
    localparam int          LONG_HOLD   = 600;
    localparam int          SETTLE      = 150;
    localparam logic [63:0] ENERGY_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [PADDR_W-1:0] ADDR_DARK_THR = {REG_DARK_THR, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_DARK_MS  = {REG_DARK_MS, 2'b00};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_pvdea_in          i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_pvdea_out         o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pv_daily_energy_accumulator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state and register copies
    logic [VOLT_W-1:0] thr_cfg      = DARK_THR_RST;
    logic [TIME_W-1:0] dark_len_cfg = DARK_MS_RST;
    logic              in_night     = 1'b0;
    logic [TIME_W-1:0] dusk_time    = '0;
    logic              dark_long    = 1'b0;
    logic [TIME_W-1:0] prev_time    = '0;
    logic              need_time_ref = 1'b1;
    logic [63:0]       energy_sum   = '0;

    t_pvdea_out expected_reports[$];
    int         mismatches   = 0;
    int         idle_pct     = 0;
    int         stall_pct    = 0;
    int         holds_asked  = 0;
    int         holds_served = 0;
    int         hold_left    = 0;
    int         quiet_cycles = 0;
    logic [TIME_W-1:0] gen_clock       = 32'h0010_0000;
    logic [TIME_W-1:0] gen_night_begin = '0;

    function automatic t_pvdea_out predict_energy(t_pvdea_in s);
        t_pvdea_out  r;
        logic [63:0] pw;
        logic [63:0] prod;
        logic [31:0] span;
        r = '0;
        if (s.pv_voltage <= thr_cfg) begin
            if (!in_night) begin
                in_night  = 1'b1;
                dusk_time = s.time_ms;
                dark_long = 1'b0;
            end else begin
                span = s.time_ms - dusk_time;
                if (span >= dark_len_cfg) dark_long = 1'b1;
            end
            prev_time = s.time_ms;
        end else begin
            if (in_night) begin
                r.sunrise_seen = 1'b1;
                if (dark_long) begin
                    energy_sum       = '0;
                    dark_long        = 1'b0;
                    r.energy_cleared = 1'b1;
                end
                in_night = 1'b0;
            end
            pw   = (s.pv_power != '0) ? 64'(s.pv_power)
                                      : 64'(s.pv_voltage) * 64'(s.pv_current);
            span = s.time_ms - prev_time;
            if (need_time_ref) begin
                need_time_ref = 1'b0;
            end else begin
                prod = pw * 64'(span);
                if (prod > ENERGY_MAX - energy_sum) energy_sum = ENERGY_MAX;
                else energy_sum = energy_sum + prod;
            end
            prev_time = s.time_ms;
        end
        r.energy_total = energy_sum[ENERGY_W-1:0];
        r.night_now    = in_night;
        r.reset_armed  = dark_long;
        return r;
    endfunction

    function automatic t_pvdea_in sample(logic [TIME_W-1:0] t, logic [VOLT_W-1:0] v,
                                         logic [CURR_W-1:0] c, logic [PWR_W-1:0] p);
        t_pvdea_in s;
        s.time_ms    = t;
        s.pv_voltage = v;
        s.pv_current = c;
        s.pv_power   = p;
        return s;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ---- stimulus helpers ----

    task automatic send_sample(t_pvdea_in s);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do @(posedge i_clk); while (o_in_stall);
        expected_reports.push_back(predict_energy(s));
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DARK_THR) thr_cfg = val[VOLT_W-1:0];
        else dark_len_cfg = val;
        @(posedge i_clk);
    endtask

    task automatic set_limits(logic [VOLT_W-1:0] thr, logic [TIME_W-1:0] dms);
        wait_all_results();
        write_reg(ADDR_DARK_THR, PDATA_W'(thr));
        write_reg(ADDR_DARK_MS, dms);
    endtask

    function automatic logic [VOLT_W-1:0] dark_volt();
        if ($urandom_range(9) == 0) return thr_cfg;
        return VOLT_W'($urandom_range(32'(thr_cfg)));
    endfunction

    function automatic logic [VOLT_W-1:0] day_volt();
        if (thr_cfg == '1) return VOLT_W'($urandom);
        case ($urandom_range(9))
            0:       return thr_cfg + 1'b1;
            1:       return '1;
            default: return VOLT_W'($urandom_range(16383, 32'(thr_cfg) + 1));
        endcase
    endfunction

    function automatic logic [CURR_W-1:0] rand_current();
        if ($urandom_range(4) == 0) return CURR_W'($urandom);
        return CURR_W'($urandom_range(10000));
    endfunction

    function automatic logic [PWR_W-1:0] rand_power();
        case ($urandom_range(9))
            0, 1, 2: return '0;
            3:       return '1;
            4, 5, 6: return PWR_W'($urandom_range(20000000));
            default: return PWR_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] day_step();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(60000, 1);
        endcase
    endfunction

    task automatic send_day();
        gen_clock = gen_clock + day_step();
        send_sample(sample(gen_clock, day_volt(), rand_current(), rand_power()));
    endtask

    // ---- tests ----

    task automatic test_directed();
        logic [TIME_W-1:0] t;
        // night first after reset: arming and a sunrise clear on the first day item
        t = 32'd100;
        send_sample(sample(t, 300, 500, 0));
        send_sample(sample(t + DARK_MS_RST - 1, 0, 0, 0));
        send_sample(sample(t + DARK_MS_RST, 12, 3, 0));
        t = t + DARK_MS_RST + 5;
        send_sample(sample(t, 301, '1, 0));
        t = t + 1000;
        send_sample(sample(t, '1, '1, 0));
        send_sample(sample(t, 5000, 0, '1));
        t = t - 1;
        send_sample(sample(t, 5000, 100, '1));
        t = t + 777;
        send_sample(sample(t, 5000, 0, 0));
        t = t + 10;
        send_sample(sample(t, 0, 0, 0));
        t = t + 10;
        send_sample(sample(t, 2000, 300, 0));
        send_sample(sample(32'hFFFF_FF00, 4000, 250, 1234));
        send_sample(sample(32'h0000_0100, 4000, 250, 0));
        // widest night span
        set_limits('1, '1);
        t = 32'h1234_5678;
        send_sample(sample(t, '1, 1, 1));
        send_sample(sample(t - 2, 14'h2AAA, 1, 1));
        send_sample(sample(t - 1, 14'h1555, 1, 1));
        // threshold dropped mid-night; zero span arms at once
        set_limits('0, '0);
        send_sample(sample(t + 5, 1, 9, 0));
        send_sample(sample(t + 6, 0, 0, 0));
        send_sample(sample(t + 6, 0, 7, 0));
        send_sample(sample(t + 9, 1, 1, 1));
    endtask

    task automatic test_saturation();
        logic [TIME_W-1:0] t;
        set_limits(300, 50000);
        t = 32'h4000_0000;
        send_sample(sample(t, 9000, 100, '1));
        repeat (18) begin
            t = t - 1;
            send_sample(sample(t, 9000, 100, '1));
        end
        t = t + 32'hF000_0000;
        send_sample(sample(t, '1, '1, 0));
        send_sample(sample(t + 1, 0, 0, 0));
        send_sample(sample(t + 50001, 200, 0, 0));
        send_sample(sample(t + 50100, 9000, 1000, 0));
        send_sample(sample(t + 51100, 9000, 1000, 0));
        gen_clock = t + 51100;
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        holds_asked++;
        repeat (12) send_day();
        repeat (5) send_day();
        wait_all_results();
        repeat (5) send_day();
    endtask

    task automatic test_random_traffic(int idle, int stall, logic [VOLT_W-1:0] thr,
                                       logic [TIME_W-1:0] dms, int n_items);
        int                sent;
        int                k;
        logic [TIME_W-1:0] off;
        set_limits(thr, dms);
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < n_items) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    k = $urandom_range(6, 1);
                    gen_clock       = gen_clock + $urandom_range(5000);
                    gen_night_begin = gen_clock;
                    send_sample(sample(gen_clock, dark_volt(), rand_current(), rand_power()));
                    repeat (k - 1) begin
                        case ($urandom_range(4))
                            0:       off = dark_len_cfg - 1;
                            1:       off = dark_len_cfg;
                            2:       off = $urandom_range(dark_len_cfg);
                            3:       off = $urandom;
                            default: off = gen_clock - gen_night_begin + $urandom_range(1000);
                        endcase
                        gen_clock = gen_night_begin + off;
                        send_sample(sample(gen_clock, dark_volt(), rand_current(), rand_power()));
                    end
                    k = k + $urandom_range(4, 1);
                    repeat (k - (k - $urandom_range(4, 1))) send_day();
                end
                8, 9, 10, 11, 12, 13, 14: begin
                    k = $urandom_range(8, 1);
                    repeat (k) send_day();
                end
                15, 16: begin
                    k = 3;
                    repeat (k) begin
                        gen_clock = gen_clock + $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
                        send_sample(sample(gen_clock, day_volt(), rand_current(),
                                           PWR_W'($urandom_range(32'h7FF_FFFF, 32'h400_0000))));
                    end
                end
                default: begin
                    k = $urandom_range(3, 1);
                    repeat (k) begin
                        gen_clock = $urandom;
                        send_sample(sample(gen_clock, VOLT_W'($urandom), CURR_W'($urandom),
                                           PWR_W'($urandom)));
                    end
                end
            endcase
            sent = sent + k;
        end
    endtask

    // ---- result checking ----

    always @(posedge i_clk) begin
        t_pvdea_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, o_out_data);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                check_field("energy_total", 64'(want.energy_total), 64'(o_out_data.energy_total));
                check_field("night_now", 64'(want.night_now), 64'(o_out_data.night_now));
                check_field("reset_armed", 64'(want.reset_armed), 64'(o_out_data.reset_armed));
                check_field("sunrise_seen", 64'(want.sunrise_seen),
                            64'(o_out_data.sunrise_seen));
                check_field("energy_cleared", 64'(want.energy_cleared),
                            64'(o_out_data.energy_cleared));
            end
        end
    end

    // receiver stall, with an occasional long hold-off on request
    always @(posedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("pv_daily_energy_accumulator_unit_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_backpressure();
        test_random_traffic(0, 0, DARK_THR_RST, DARK_MS_RST, 240);
        test_random_traffic(79, 0, '0, 32'd1, 230);
        test_random_traffic(0, 79, '1, 32'd5000, 80);
        test_random_traffic(37, 37, 14'd9000, '1, 230);
        test_random_traffic(0, 0, VOLT_W'($urandom_range(10000)),
                            $urandom_range(200000, 1), 230);
        test_random_traffic(37, 37, 14'd100, 32'd50000, 230);

        wait_all_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("pv_daily_energy_accumulator_unit_test OK");
        end else begin
            $display("pv_daily_energy_accumulator_unit_test NOT OK");
        end
        $finish;
    end

endmodule

// File: pv_daily_energy_accumulator_unit.f
hw/rtl/pvdea_pkg.sv
hw/rtl/pvdea_mul.sv
hw/rtl/pvdea_acc.sv
hw/rtl/pv_daily_energy_accumulator_unit.sv
tb/pv_daily_energy_accumulator_unit_test.sv
